// ----- src/rop_pkg.sv -----
package rop_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 256;
    localparam int DEFAULT_MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

    localparam logic [7:0] PIXEL_ON  = 8'hFF;
    localparam logic [7:0] PIXEL_OFF = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ROWS,
        ST_DRAIN,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

endpackage

// ----- src/rop_frame_mem.sv -----
module rop_frame_mem
    import rop_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  mem_cmd_t                      cmd,
    input  logic [$clog2(MAX_HEIGHT)-1:0] rd_addr,
    input  logic [$clog2(MAX_HEIGHT)-1:0] wr_addr,
    input  logic [MAX_WIDTH-1:0]          wr_data,
    output logic [MAX_WIDTH-1:0]          rd_data
);

    // one word per image row
    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rop_ctrl.sv -----
module rop_ctrl
    import rop_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [7:0]                      s_x_left,
    input  logic [7:0]                      s_x_right,
    input  logic [7:0]                      s_y_top,
    input  logic [7:0]                      s_y_bottom,
    input  logic                            s_draw_enable,
    input  logic [7:0]                      s_pixel_x,
    input  logic [7:0]                      s_pixel_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_pixel_value,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] eff_height,
    output mem_cmd_t                        mem_cmd,
    output logic [$clog2(MAX_HEIGHT)-1:0]   mem_rd_addr,
    output logic [$clog2(MAX_HEIGHT)-1:0]   mem_wr_addr,
    output logic [MAX_WIDTH-1:0]            mem_wr_data,
    input  logic [MAX_WIDTH-1:0]            mem_rd_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = (YW > 8) ? YW : 8;
    localparam int CW = (RW > HW) ? RW : HW;

    state_t               state_reg, state_next;
    logic [RW-1:0]        row_reg;
    logic [RW-1:0]        hi_reg;
    logic [7:0]           yt_reg, yb_reg;
    logic                 clear_reg;
    logic [MAX_WIDTH-1:0] hmask_reg, vmask_reg;
    logic                 pend_valid_reg;
    logic [YW-1:0]        pend_row_reg;
    logic [MAX_WIDTH-1:0] pend_mask_reg;
    logic [XW-1:0]        px_reg;
    logic                 rd_in_frame_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_pixel_reg;

    logic                 accept;
    logic                 out_load;
    logic [MAX_WIDTH-1:0] clr_mask, span_mask, side_mask, row_mask;
    logic                 row_is_edge, row_in_span, row_in_frame;
    logic [RW-1:0]        lo_sel, hi_sel;

    // column masks for the incoming transaction
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            clr_mask[i]  = i < int'(eff_width);
            span_mask[i] = clr_mask[i] && (i >= int'(s_x_left)) && (i <= int'(s_x_right));
            side_mask[i] = clr_mask[i] && (s_y_top <= s_y_bottom)
                           && ((i == int'(s_x_left)) || (i == int'(s_x_right)));
        end
    end

    always_comb begin
        if (action_t'(s_action) == ACT_CLEAR) begin
            lo_sel = '0;
            hi_sel = RW'(HW'(eff_height - 1'b1));
        end else if (s_y_top <= s_y_bottom) begin
            lo_sel = RW'(s_y_top);
            hi_sel = RW'(s_y_bottom);
        end else begin
            lo_sel = RW'(s_y_bottom);
            hi_sel = RW'(s_y_top);
        end
    end

    // per-row mask during a row pass
    always_comb begin
        row_is_edge  = (row_reg == RW'(yt_reg)) || (row_reg == RW'(yb_reg));
        row_in_span  = (row_reg >= RW'(yt_reg)) && (row_reg <= RW'(yb_reg));
        row_in_frame = CW'(row_reg) < CW'(eff_height);
        if (clear_reg) begin
            row_mask = hmask_reg;
        end else begin
            row_mask = (row_is_edge ? hmask_reg : '0) | (row_in_span ? vmask_reg : '0);
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        accept          = 1'b0;
        out_load        = 1'b0;
        mem_cmd.rd_en   = 1'b0;
        mem_cmd.wr_en   = (state_reg == ST_INIT) || pend_valid_reg;
        mem_rd_addr     = row_reg[YW-1:0];
        unique case (state_reg)
            ST_INIT: begin
                if (row_reg == RW'(MAX_HEIGHT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    accept = 1'b1;
                    unique case (action_t'(s_action))
                        ACT_CLEAR: begin
                            if (eff_height != '0) begin
                                state_next = ST_ROWS;
                            end
                        end
                        ACT_DRAW: begin
                            if (s_draw_enable) begin
                                state_next = ST_ROWS;
                            end
                        end
                        ACT_READ: begin
                            mem_cmd.rd_en = 1'b1;
                            mem_rd_addr   = YW'(s_pixel_y);
                            state_next    = ST_DATA;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROWS: begin
                mem_cmd.rd_en = 1'b1;
                if (row_reg == hi_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_DATA: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // write port: zero sweep after reset, otherwise the pending modified row
    always_comb begin
        if (state_reg == ST_INIT) begin
            mem_wr_addr = row_reg[YW-1:0];
            mem_wr_data = '0;
        end else begin
            mem_wr_addr = pend_row_reg;
            mem_wr_data = clear_reg ? (mem_rd_data & ~pend_mask_reg)
                                    : (mem_rd_data | pend_mask_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= (state_reg == ST_ROWS) && row_in_frame;
            if (state_reg == ST_INIT) begin
                row_reg <= row_reg + 1'b1;
            end else if (accept) begin
                row_reg <= lo_sel;
            end else if (state_reg == ST_ROWS && row_reg != hi_reg) begin
                row_reg <= row_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hi_reg          <= hi_sel;
            yt_reg          <= s_y_top;
            yb_reg          <= s_y_bottom;
            clear_reg       <= action_t'(s_action) == ACT_CLEAR;
            hmask_reg       <= (action_t'(s_action) == ACT_CLEAR) ? clr_mask : span_mask;
            vmask_reg       <= side_mask;
            px_reg          <= XW'(s_pixel_x);
            rd_in_frame_reg <= (int'(s_pixel_x) < int'(eff_width))
                               && (int'(s_pixel_y) < int'(eff_height));
        end
        pend_row_reg  <= row_reg[YW-1:0];
        pend_mask_reg <= row_mask;
        if (out_load) begin
            m_pixel_reg <= (rd_in_frame_reg && mem_rd_data[px_reg]) ? PIXEL_ON : PIXEL_OFF;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_reg;

endmodule

// ----- src/rectangle_outline_plotter_unit.sv -----
// Rectangle outline plotter: a one-bit frame store of MAX_HEIGHT rows by MAX_WIDTH
// columns, held as one memory word per row.
// Input channel s_*: valid/ready; s_action selects clear (0), draw outline (1) or
// read one pixel (2). Fields an action does not use are ignored; action 3 is dropped.
// Result channel m_*: valid/ready; only a read gives a result, m_pixel_value 0 or 255.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the column count (0) or the row
// count (1); write only while the block is idle.
// Each action works on the frame memory as follows:
//   read  : the row is registered in the memory, then the pixel in the output register
//   clear : a read-modify-write pass over every effective row, one row per cycle
//   draw  : a pass over rows y_top to y_bottom, one row per cycle; none if disabled
// A new input is taken once the current one is done, even while a result still
// waits in the output register; a read then holds its data until the receiver takes
// the earlier result.
// Reset: registers return to 256 x 256 and a sweep writes every row to zero, while
// s_ready stays low; configuration writes still land.
module rectangle_outline_plotter_unit
    import rop_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [7:0]           s_x_left,
    input  logic [7:0]           s_x_right,
    input  logic [7:0]           s_y_top,
    input  logic [7:0]           s_y_bottom,
    input  logic                 s_draw_enable,
    input  logic [7:0]           s_pixel_x,
    input  logic [7:0]           s_pixel_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_pixel_value
);

    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
    localparam int HCW = (HW > CFG_W) ? HW : CFG_W;

    logic [CFG_W-1:0]     cols_cfg_reg, rows_cfg_reg;
    logic [WCW-1:0]       width_ext;
    logic [HCW-1:0]       height_ext;
    logic [WW-1:0]        eff_width;
    logic [HW-1:0]        eff_height;
    mem_cmd_t             mem_cmd;
    logic [YW-1:0]        mem_rd_addr, mem_wr_addr;
    logic [MAX_WIDTH-1:0] mem_wr_data, mem_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= CFG_SIZE_RESET;
            rows_cfg_reg <= CFG_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COLS: cols_cfg_reg <= cfg_data;
                CFG_ROWS: rows_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sizes above the store act as the store size
    always_comb begin
        width_ext  = WCW'(cols_cfg_reg);
        height_ext = HCW'(rows_cfg_reg);
        eff_width  = (width_ext > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
        eff_height = (height_ext > HCW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);
    end

    rop_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_x_left      (s_x_left),
        .s_x_right     (s_x_right),
        .s_y_top       (s_y_top),
        .s_y_bottom    (s_y_bottom),
        .s_draw_enable (s_draw_enable),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .mem_cmd       (mem_cmd),
        .mem_rd_addr   (mem_rd_addr),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_data   (mem_rd_data)
    );

    rop_frame_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame_mem (
        .aclk    (aclk),
        .cmd     (mem_cmd),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

`ifndef SYNTH
    // the zero sweep holds off input right after reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input accepted during frame sweep");

    // a read transaction keeps the block busy on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == ACT_READ) |=> !s_ready)
        else $error("read did not hold off input");

    // results are only background or outline values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_value == PIXEL_ON || m_pixel_value == PIXEL_OFF))
        else $error("bad pixel value");

    // no row write is still pending when a transaction is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !mem_cmd.wr_en)
        else $error("row write pending while idle");
`endif

endmodule
